FILE: hw/rtl/mbef_pkg.sv
// Shared types, constants and codes of the mesh boundary edge finder.
`timescale 1ns / 1ps
`default_nettype none

package mbef_pkg;

    localparam int MAX_NODES     = 64;
    localparam int MAX_TRIANGLES = 64;
    localparam int NODE_IDX_W    = 6;
    localparam int CNT_W         = 7;
    localparam int COORD_W       = 32;
    localparam int TOL_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;

    localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(66);

    typedef enum logic [1:0] {
        KIND_WR_NODE  = 2'd0,
        KIND_WR_TRI   = 2'd1,
        KIND_Q_NODE   = 2'd2,
        KIND_Q_EDGE   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        SIDE_TOP    = 2'd0,
        SIDE_BOTTOM = 2'd1,
        SIDE_LEFT   = 2'd2,
        SIDE_RIGHT  = 2'd3
    } side_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOLERANCE = 2'd0,
        CFG_NODES     = 2'd1,
        CFG_ELEMENTS  = 2'd2
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ADDR_IDX = 2'd0,
        ADDR_VA  = 2'd1,
        ADDR_VB  = 2'd2,
        ADDR_VC  = 2'd3
    } addr_sel_t;

    typedef enum logic [1:0] {
        VERT_A = 2'd0,
        VERT_B = 2'd1,
        VERT_C = 2'd2
    } vert_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EXT,
        S_EXT_DRAIN,
        S_NODE,
        S_NODE_DRAIN,
        S_TRI,
        S_VA,
        S_VB,
        S_VC,
        S_CAPC,
        S_EVAL,
        S_FIN
    } state_t;

    typedef struct packed {
        logic [1:0]                kind;
        logic [NODE_IDX_W-1:0]     slot;
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic [NODE_IDX_W-1:0]     vertex_a;
        logic [NODE_IDX_W-1:0]     vertex_b;
        logic [NODE_IDX_W-1:0]     vertex_c;
        logic [1:0]                side;
    } mbef_in_t;

    typedef struct packed {
        logic                      found;
        logic [NODE_IDX_W-1:0]     element_index;
        logic [NODE_IDX_W-1:0]     first_node;
        logic [NODE_IDX_W-1:0]     second_node;
        logic signed [COORD_W-1:0] mid_x;
        logic signed [COORD_W-1:0] mid_y;
        logic                      last;
    } mbef_out_t;

    typedef struct packed {
        logic [NODE_IDX_W-1:0] a;
        logic [NODE_IDX_W-1:0] b;
        logic [NODE_IDX_W-1:0] c;
    } tri_t;

    // controller -> datapath
    typedef struct packed {
        logic                  wr_node;
        logic                  wr_tri;
        logic                  qstart;
        logic                  tri_rd;
        logic                  ext_rd;
        logic                  ext_first;
        logic                  node_chk;
        logic                  cap_en;
        vert_t                 cap_sel;
        logic                  edge_eval;
        logic                  finish;
        addr_sel_t             addr_sel;
        logic [NODE_IDX_W-1:0] idx;
    } mbef_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [CNT_W-1:0] nn;
        logic [CNT_W-1:0] ne;
    } mbef_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/mbef_ctrl.sv
// Query sequencer of the mesh boundary edge finder.
`timescale 1ns / 1ps
`default_nettype none

module mbef_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [1:0]         kind,
    input  wire mbef_pkg::mbef_stat_t stat,
    output mbef_pkg::mbef_cmd_t     cmd,
    output logic                    busy
);

    mbef_pkg::state_t                state_reg, state_next;
    logic [mbef_pkg::CNT_W-1:0]      idx_reg, idx_next;
    logic                            edge_reg, edge_next;
    logic                            idx_last_node;
    logic                            idx_last_tri;
    logic                            accept;

    assign busy          = (state_reg != mbef_pkg::S_IDLE);
    assign accept        = start && !busy;
    assign idx_last_node = ((idx_reg + mbef_pkg::CNT_W'(1)) == stat.nn);
    assign idx_last_tri  = ((idx_reg + mbef_pkg::CNT_W'(1)) == stat.ne);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbef_pkg::S_IDLE;
            idx_reg   <= '0;
            edge_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            edge_reg  <= edge_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        edge_next     = edge_reg;
        cmd           = '0;
        cmd.addr_sel  = mbef_pkg::ADDR_IDX;
        cmd.cap_sel   = mbef_pkg::VERT_A;
        cmd.idx       = idx_reg[mbef_pkg::NODE_IDX_W-1:0];

        unique case (state_reg)
            mbef_pkg::S_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    unique case (mbef_pkg::kind_t'(kind)) inside
                        mbef_pkg::KIND_WR_NODE: cmd.wr_node = 1'b1;
                        mbef_pkg::KIND_WR_TRI:  cmd.wr_tri  = 1'b1;
                        mbef_pkg::KIND_Q_NODE, mbef_pkg::KIND_Q_EDGE:
                        begin
                            cmd.qstart = 1'b1;
                            edge_next  = (mbef_pkg::kind_t'(kind) == mbef_pkg::KIND_Q_EDGE);
                            state_next = (stat.nn == '0) ? mbef_pkg::S_FIN : mbef_pkg::S_EXT;
                        end
                        default: ;
                    endcase
                end
            end
            mbef_pkg::S_EXT:
            begin
                cmd.ext_rd    = 1'b1;
                cmd.ext_first = (idx_reg == '0);
                if (idx_last_node)
                begin
                    idx_next   = '0;
                    state_next = mbef_pkg::S_EXT_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + mbef_pkg::CNT_W'(1);
                end
            end
            mbef_pkg::S_EXT_DRAIN:
            begin
                if (!edge_reg)
                    state_next = mbef_pkg::S_NODE;
                else if (stat.ne == '0)
                    state_next = mbef_pkg::S_FIN;
                else
                    state_next = mbef_pkg::S_TRI;
            end
            mbef_pkg::S_NODE:
            begin
                cmd.node_chk = 1'b1;
                if (idx_last_node)
                    state_next = mbef_pkg::S_NODE_DRAIN;
                else
                    idx_next = idx_reg + mbef_pkg::CNT_W'(1);
            end
            mbef_pkg::S_NODE_DRAIN:
            begin
                state_next = mbef_pkg::S_FIN;
            end
            mbef_pkg::S_TRI:
            begin
                cmd.tri_rd = 1'b1;
                state_next = mbef_pkg::S_VA;
            end
            mbef_pkg::S_VA:
            begin
                cmd.addr_sel = mbef_pkg::ADDR_VA;
                state_next   = mbef_pkg::S_VB;
            end
            mbef_pkg::S_VB:
            begin
                // vertex a data returns while b is read
                cmd.addr_sel = mbef_pkg::ADDR_VB;
                cmd.cap_en   = 1'b1;
                cmd.cap_sel  = mbef_pkg::VERT_A;
                state_next   = mbef_pkg::S_VC;
            end
            mbef_pkg::S_VC:
            begin
                cmd.addr_sel = mbef_pkg::ADDR_VC;
                cmd.cap_en   = 1'b1;
                cmd.cap_sel  = mbef_pkg::VERT_B;
                state_next   = mbef_pkg::S_CAPC;
            end
            mbef_pkg::S_CAPC:
            begin
                cmd.cap_en  = 1'b1;
                cmd.cap_sel = mbef_pkg::VERT_C;
                state_next  = mbef_pkg::S_EVAL;
            end
            mbef_pkg::S_EVAL:
            begin
                cmd.edge_eval = 1'b1;
                if (idx_last_tri)
                begin
                    state_next = mbef_pkg::S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + mbef_pkg::CNT_W'(1);
                    state_next = mbef_pkg::S_TRI;
                end
            end
            mbef_pkg::S_FIN:
            begin
                cmd.finish = 1'b1;
                state_next = mbef_pkg::S_IDLE;
            end
            default:
            begin
                state_next = mbef_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: hw/rtl/mbef_datapath.sv
// Node and triangle stores, config registers, extreme search and result staging.
`timescale 1ns / 1ps
`default_nettype none

module mbef_datapath
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire mbef_pkg::mbef_cmd_t               cmd,
    input  wire mbef_pkg::mbef_in_t                item,
    input  wire logic                              cfg_valid,
    input  wire logic [mbef_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mbef_pkg::CFG_DATA_W-1:0]   cfg_data,
    output mbef_pkg::mbef_stat_t                   stat,
    output logic                                   result_strobe,
    output mbef_pkg::mbef_out_t                    result
);

    localparam int CW = mbef_pkg::COORD_W;
    localparam int IW = mbef_pkg::NODE_IDX_W;

    function automatic logic near_lim(input logic signed [CW-1:0] c,
                                      input logic signed [CW-1:0] lim,
                                      input logic [mbef_pkg::TOL_W-1:0] tol);
        logic [CW:0] d;
        logic [CW:0] mag;
        d   = {c[CW-1], c} - {lim[CW-1], lim};
        mag = d[CW] ? (~d + (CW+1)'(1)) : d;
        return mag < (CW+1)'(tol);
    endfunction

    // stores
    logic signed [CW-1:0] node_x_mem [mbef_pkg::MAX_NODES];
    logic signed [CW-1:0] node_y_mem [mbef_pkg::MAX_NODES];
    mbef_pkg::tri_t       tri_mem    [mbef_pkg::MAX_TRIANGLES];

    logic [mbef_pkg::TOL_W-1:0] tol_reg;
    logic [mbef_pkg::CNT_W-1:0] nodes_reg;
    logic [mbef_pkg::CNT_W-1:0] elems_reg;

    logic signed [CW-1:0] rdx_reg, rdy_reg;
    mbef_pkg::tri_t       tri_rd_reg;
    logic [IW-1:0]        rd_addr;

    logic [1:0]           side_reg;
    logic                 use_y, want_max;
    logic signed [CW-1:0] coord_rd;
    logic signed [CW-1:0] lim_reg;
    logic                 acc_v_reg, acc_first_reg;
    logic                 chk_v_reg;
    logic [IW-1:0]        chk_idx_reg;

    logic signed [CW-1:0] vx_reg [3];
    logic signed [CW-1:0] vy_reg [3];
    logic                 vm_reg [3];

    logic                 hit;
    mbef_pkg::mbef_out_t  new_res;
    mbef_pkg::mbef_out_t  fin_res;
    mbef_pkg::mbef_out_t  pend_reg;
    logic                 pend_v_reg;
    mbef_pkg::mbef_out_t  out_reg;
    logic                 strobe_reg;

    logic                 e_hit;
    logic [IW-1:0]        e_p, e_q;
    logic signed [CW-1:0] e_px, e_py, e_qx, e_qy;
    logic [CW:0]          sum_x, sum_y;

    // config
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg   <= mbef_pkg::TOL_RESET;
            nodes_reg <= '0;
            elems_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (mbef_pkg::cfg_idx_t'(cfg_index))
                mbef_pkg::CFG_TOLERANCE: tol_reg   <= cfg_data[mbef_pkg::TOL_W-1:0];
                mbef_pkg::CFG_NODES:     nodes_reg <= cfg_data[mbef_pkg::CNT_W-1:0];
                mbef_pkg::CFG_ELEMENTS:  elems_reg <= cfg_data[mbef_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign stat.nn = (nodes_reg > mbef_pkg::CNT_W'(mbef_pkg::MAX_NODES))
                   ? mbef_pkg::CNT_W'(mbef_pkg::MAX_NODES) : nodes_reg;
    assign stat.ne = (elems_reg > mbef_pkg::CNT_W'(mbef_pkg::MAX_TRIANGLES))
                   ? mbef_pkg::CNT_W'(mbef_pkg::MAX_TRIANGLES) : elems_reg;

    always_comb
    begin
        unique case (cmd.addr_sel)
            mbef_pkg::ADDR_VA: rd_addr = tri_rd_reg.a;
            mbef_pkg::ADDR_VB: rd_addr = tri_rd_reg.b;
            mbef_pkg::ADDR_VC: rd_addr = tri_rd_reg.c;
            default:           rd_addr = cmd.idx;
        endcase
    end

    // memories: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.wr_node)
        begin
            node_x_mem[item.slot] <= item.x_coord;
            node_y_mem[item.slot] <= item.y_coord;
        end
        rdx_reg <= node_x_mem[rd_addr];
        rdy_reg <= node_y_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_tri)
            tri_mem[item.slot] <= '{a: item.vertex_a, b: item.vertex_b, c: item.vertex_c};
        if (cmd.tri_rd)
            tri_rd_reg <= tri_mem[cmd.idx];
    end

    assign use_y    = (side_reg == mbef_pkg::SIDE_TOP) || (side_reg == mbef_pkg::SIDE_BOTTOM);
    assign want_max = (side_reg == mbef_pkg::SIDE_TOP) || (side_reg == mbef_pkg::SIDE_RIGHT);
    assign coord_rd = use_y ? rdy_reg : rdx_reg;

    // delayed read strobes line up with registered read data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_v_reg     <= 1'b0;
            acc_first_reg <= 1'b0;
            chk_v_reg     <= 1'b0;
        end
        else
        begin
            acc_v_reg     <= cmd.ext_rd;
            acc_first_reg <= cmd.ext_first;
            chk_v_reg     <= cmd.node_chk;
        end
    end

    always_ff @(posedge clk)
    begin
        chk_idx_reg <= cmd.idx;
        if (cmd.qstart)
            side_reg <= item.side;
        if (acc_v_reg)
        begin
            if (acc_first_reg || (want_max ? (coord_rd > lim_reg) : (coord_rd < lim_reg)))
                lim_reg <= coord_rd;
        end
        if (cmd.cap_en)
        begin
            case (cmd.cap_sel)
                mbef_pkg::VERT_A:
                begin
                    vx_reg[0] <= rdx_reg;
                    vy_reg[0] <= rdy_reg;
                    vm_reg[0] <= near_lim(coord_rd, lim_reg, tol_reg);
                end
                mbef_pkg::VERT_B:
                begin
                    vx_reg[1] <= rdx_reg;
                    vy_reg[1] <= rdy_reg;
                    vm_reg[1] <= near_lim(coord_rd, lim_reg, tol_reg);
                end
                default:
                begin
                    vx_reg[2] <= rdx_reg;
                    vy_reg[2] <= rdy_reg;
                    vm_reg[2] <= near_lim(coord_rd, lim_reg, tol_reg);
                end
            endcase
        end
    end

    // first boundary edge of the triangle: a-b, then b-c, then c-a
    always_comb
    begin
        e_hit = 1'b1;
        if (vm_reg[0] && vm_reg[1])
        begin
            e_p = tri_rd_reg.a; e_q = tri_rd_reg.b;
            e_px = vx_reg[0]; e_py = vy_reg[0]; e_qx = vx_reg[1]; e_qy = vy_reg[1];
        end
        else if (vm_reg[1] && vm_reg[2])
        begin
            e_p = tri_rd_reg.b; e_q = tri_rd_reg.c;
            e_px = vx_reg[1]; e_py = vy_reg[1]; e_qx = vx_reg[2]; e_qy = vy_reg[2];
        end
        else
        begin
            e_hit = vm_reg[2] && vm_reg[0];
            e_p = tri_rd_reg.c; e_q = tri_rd_reg.a;
            e_px = vx_reg[2]; e_py = vy_reg[2]; e_qx = vx_reg[0]; e_qy = vy_reg[0];
        end
        sum_x = {e_px[CW-1], e_px} + {e_qx[CW-1], e_qx};
        sum_y = {e_py[CW-1], e_py} + {e_qy[CW-1], e_qy};
    end

    always_comb
    begin
        new_res = '0;
        hit     = 1'b0;
        if (chk_v_reg)
        begin
            hit                = near_lim(coord_rd, lim_reg, tol_reg);
            new_res.found      = 1'b1;
            new_res.first_node = chk_idx_reg;
        end
        else if (cmd.edge_eval)
        begin
            hit                   = e_hit;
            new_res.found         = 1'b1;
            new_res.element_index = cmd.idx;
            new_res.first_node    = e_p;
            new_res.second_node   = e_q;
            new_res.mid_x         = sum_x[CW:1];
            new_res.mid_y         = sum_y[CW:1];
        end
    end

    // closing result: the held one, or an empty one, marked last
    always_comb
    begin
        fin_res      = pend_v_reg ? pend_reg : '0;
        fin_res.last = 1'b1;
    end

    // one result held back so the final one can carry last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cmd.qstart)
            begin
                pend_v_reg <= 1'b0;
            end
            else if (hit)
            begin
                pend_v_reg <= 1'b1;
                strobe_reg <= pend_v_reg;
            end
            else if (cmd.finish)
            begin
                pend_v_reg <= 1'b0;
                strobe_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            pend_reg <= new_res;
            out_reg  <= pend_reg;
        end
        else if (cmd.finish)
        begin
            out_reg <= fin_res;
        end
    end

    assign result_strobe = strobe_reg;
    assign result        = out_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/mesh_boundary_edge_finder_top.sv
// Top level of the mesh boundary edge finder.
//
// Item channel: an item is taken at a rising edge with start high and busy low.
// Node and triangle writes (kinds 0 and 1) keep busy low, so writes can be
// issued back to back. A query (kinds 2 and 3) raises busy.
// A query first reads every node in use once to find the side extreme
// (one node-store read per cycle), then:
//   node query: reads the nodes again;
//   edge query: for each triangle one triangle read, three vertex reads,
//   capture and selection.
// With no nodes in use a query gives only its closing result.
// Results appear on result for one cycle with result_strobe high; the last
// one of a query has last set and comes in the cycle in which busy falls.
// There is no stall: the receiver takes every result as it comes.
// Config channel: cfg_ready is always high; write only while the block is idle.
// Reset clears the config registers to their defaults and the sequencer to
// idle; the node and triangle stores are not cleared and must be written
// before they are used.
`timescale 1ns / 1ps
`default_nettype none

module mesh_boundary_edge_finder_top
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire mbef_pkg::mbef_in_t                item,
    output logic                                   result_strobe,
    output mbef_pkg::mbef_out_t                    result,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [mbef_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [mbef_pkg::CFG_DATA_W-1:0]   cfg_data
);

    mbef_pkg::mbef_cmd_t  cmd;
    mbef_pkg::mbef_stat_t stat;

    assign cfg_ready = 1'b1;

    mbef_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .kind  (item.kind),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    mbef_datapath u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .item          (item),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .stat          (stat),
        .result_strobe (result_strobe),
        .result        (result)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/mbef_checker.sv
// Port-level checks of the mesh boundary edge finder, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module mbef_checker
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                start,
    input wire logic                busy,
    input wire mbef_pkg::mbef_in_t  item,
    input wire logic                result_strobe,
    input wire mbef_pkg::mbef_out_t result
);

    logic acc_write;
    logic acc_query;

    assign acc_write = start && !busy &&
                       ((item.kind == mbef_pkg::KIND_WR_NODE) ||
                        (item.kind == mbef_pkg::KIND_WR_TRI));
    assign acc_query = start && !busy &&
                       ((item.kind == mbef_pkg::KIND_Q_NODE) ||
                        (item.kind == mbef_pkg::KIND_Q_EDGE));

    // an empty query gives a single all-zero closing result
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result.found) |-> (result.last && result.element_index == '0 &&
            result.first_node == '0 && result.second_node == '0 &&
            result.mid_x == '0 && result.mid_y == '0))
        else $error("empty result malformed");

    a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result.last) |=> !result_strobe)
        else $error("result right after last");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        acc_write |=> !busy)
        else $error("write left block busy");

    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        acc_query |=> busy)
        else $error("query did not raise busy");

endmodule

bind mesh_boundary_edge_finder_top mbef_checker u_mbef_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .item          (item),
    .result_strobe (result_strobe),
    .result        (result)
);

`default_nettype wire

FILE: verif/tb.sv
// Self-checking testbench for the mesh boundary edge finder top level.
`timescale 1ns / 1ps

module tb;
    import mbef_pkg::*;

    localparam int LIMIT_CYCLES  = 400000;
    localparam int RANDOM_ITEMS  = 180;
    localparam int SETTLE_CYCLES = 8;
    localparam int GRID_COLS     = 8;

    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;
    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;

    // Mirror of the node and triangle stores; predicts the boundary hits of each query.
    class mesh_boundary_scoreboard;
        logic signed [COORD_W-1:0] node_x [MAX_NODES];
        logic signed [COORD_W-1:0] node_y [MAX_NODES];
        tri_t                      tris [MAX_TRIANGLES];
        logic [TOL_W-1:0]          tolerance;
        logic [CNT_W-1:0]          nodes_used;
        logic [CNT_W-1:0]          elems_used;
        mbef_out_t                 expected_hits [$];
        int                        mismatches;
        bit                        failed;

        function new();
            foreach (node_x[i])
            begin
                node_x[i] = '0;
                node_y[i] = '0;
            end
            foreach (tris[i])
                tris[i] = '0;
            tolerance   = TOL_RESET;
            nodes_used  = '0;
            elems_used  = '0;
            mismatches  = 0;
            failed      = 1'b0;
        endfunction

        function void store_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_TOLERANCE: tolerance  = val[TOL_W-1:0];
                CFG_NODES:     nodes_used = val[CNT_W-1:0];
                CFG_ELEMENTS:  elems_used = val[CNT_W-1:0];
                default: ;
            endcase
        endfunction

        function bit near_extreme(logic signed [COORD_W-1:0] c, logic signed [COORD_W-1:0] lim);
            longint d;
            d = longint'(c) - longint'(lim);
            if (d < 0)
                d = -d;
            return d < longint'(tolerance);
        endfunction

        function void note_item(mbef_in_t it);
            int                        nn;
            int                        ne;
            int                        hits;
            bit                        use_y;
            bit                        want_max;
            bit                        hit;
            logic signed [COORD_W-1:0] lim;
            logic signed [COORD_W-1:0] cv;
            logic [NODE_IDX_W-1:0]     v [3];
            bit                        m [3];
            logic [NODE_IDX_W-1:0]     p;
            logic [NODE_IDX_W-1:0]     q;
            logic [COORD_W:0]          sx;
            logic [COORD_W:0]          sy;
            mbef_out_t                 r;

            if (it.kind == KIND_WR_NODE)
            begin
                node_x[it.slot] = it.x_coord;
                node_y[it.slot] = it.y_coord;
                return;
            end
            if (it.kind == KIND_WR_TRI)
            begin
                tris[it.slot] = '{a: it.vertex_a, b: it.vertex_b, c: it.vertex_c};
                return;
            end

            use_y    = (it.side == SIDE_TOP || it.side == SIDE_BOTTOM);
            want_max = (it.side == SIDE_TOP || it.side == SIDE_RIGHT);
            nn       = (nodes_used > MAX_NODES) ? MAX_NODES : int'(nodes_used);
            ne       = (elems_used > MAX_TRIANGLES) ? MAX_TRIANGLES : int'(elems_used);
            hits     = 0;
            p        = '0;
            q        = '0;

            if (nn > 0)
            begin
                lim = use_y ? node_y[0] : node_x[0];
                for (int i = 1; i < nn; i++)
                begin
                    cv = use_y ? node_y[i] : node_x[i];
                    if (want_max ? (cv > lim) : (cv < lim))
                        lim = cv;
                end
                if (it.kind == KIND_Q_NODE)
                begin
                    for (int i = 0; i < nn; i++)
                    begin
                        if (near_extreme(use_y ? node_y[i] : node_x[i], lim))
                        begin
                            r            = '0;
                            r.found      = 1'b1;
                            r.first_node = NODE_IDX_W'(i);
                            expected_hits.push_back(r);
                            hits++;
                        end
                    end
                end
                else
                begin
                    for (int i = 0; i < ne; i++)
                    begin
                        v[0] = tris[i].a;
                        v[1] = tris[i].b;
                        v[2] = tris[i].c;
                        for (int e = 0; e < 3; e++)
                            m[e] = near_extreme(use_y ? node_y[v[e]] : node_x[v[e]], lim);
                        hit = 1'b0;
                        // first edge in a-b, b-c, c-a order with both ends on the side
                        for (int e = 0; e < 3 && !hit; e++)
                        begin
                            if (m[e] && m[(e + 1) % 3])
                            begin
                                p   = v[e];
                                q   = v[(e + 1) % 3];
                                hit = 1'b1;
                            end
                        end
                        if (hit)
                        begin
                            // 33-bit sum, then drop the low bit: floor of the half
                            sx = {node_x[p][COORD_W-1], node_x[p]} + {node_x[q][COORD_W-1], node_x[q]};
                            sy = {node_y[p][COORD_W-1], node_y[p]} + {node_y[q][COORD_W-1], node_y[q]};
                            r               = '0;
                            r.found         = 1'b1;
                            r.element_index = NODE_IDX_W'(i);
                            r.first_node    = p;
                            r.second_node   = q;
                            r.mid_x         = sx[COORD_W:1];
                            r.mid_y         = sy[COORD_W:1];
                            expected_hits.push_back(r);
                            hits++;
                        end
                    end
                end
            end

            if (hits == 0)
                expected_hits.push_back('0);
            r      = expected_hits[expected_hits.size() - 1];
            r.last = 1'b1;
            expected_hits[expected_hits.size() - 1] = r;
        endfunction

        function void check_result(mbef_out_t got);
            mbef_out_t want;
            if (expected_hits.size() == 0)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing expected: found %0b first %0d last %0b",
                             $time, got.found, got.first_node, got.last);
                return;
            end
            want = expected_hits.pop_front();
            if (got.found !== want.found || got.element_index !== want.element_index ||
                got.first_node !== want.first_node || got.second_node !== want.second_node ||
                got.mid_x !== want.mid_x || got.mid_y !== want.mid_y ||
                got.last !== want.last)
            begin
                failed = 1'b1;
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: result mismatch (expected/actual) found %0b/%0b elem %0d/%0d",
                             $time, want.found, got.found, want.element_index,
                             got.element_index);
                    $display("  nodes %0d,%0d/%0d,%0d mid %0d,%0d/%0d,%0d last %0b/%0b",
                             want.first_node, want.second_node, got.first_node,
                             got.second_node, want.mid_x, want.mid_y, got.mid_x, got.mid_y,
                             want.last, got.last);
                end
            end
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  busy;
    mbef_in_t              item      = '0;
    logic                  result_strobe;
    mbef_out_t             result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    mesh_boundary_scoreboard boundary_sb;
    int idle_pct    = 29;
    int cycle_count = 0;
    int stray_slot  = -1;
    int grid_x0;
    int grid_y0;
    int grid_step;
    int grid_jitter;

    mesh_boundary_edge_finder_top DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .result_strobe (result_strobe),
        .result        (result),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
            boundary_sb.check_result(result);
    end

    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    function automatic mbef_in_t make_item(input kind_t k);
        mbef_in_t it;
        it.kind     = k;
        it.slot     = NODE_IDX_W'($urandom_range(63));
        it.x_coord  = $urandom;
        it.y_coord  = $urandom;
        it.vertex_a = NODE_IDX_W'($urandom_range(63));
        it.vertex_b = NODE_IDX_W'($urandom_range(63));
        it.vertex_c = NODE_IDX_W'($urandom_range(63));
        it.side     = 2'($urandom_range(3));
        return it;
    endfunction

    function automatic mbef_in_t node_at(input int slot, input logic signed [COORD_W-1:0] x,
                                         input logic signed [COORD_W-1:0] y);
        mbef_in_t it;
        it         = make_item(KIND_WR_NODE);
        it.slot    = NODE_IDX_W'(slot);
        it.x_coord = x;
        it.y_coord = y;
        return it;
    endfunction

    function automatic mbef_in_t tri_of(input int slot, input int a, input int b, input int c);
        mbef_in_t it;
        it          = make_item(KIND_WR_TRI);
        it.slot     = NODE_IDX_W'(slot);
        it.vertex_a = NODE_IDX_W'(a);
        it.vertex_b = NODE_IDX_W'(b);
        it.vertex_c = NODE_IDX_W'(c);
        return it;
    endfunction

    function automatic mbef_in_t grid_node(input int slot);
        return node_at(slot,
                       grid_x0 + (slot % GRID_COLS) * grid_step + int'($urandom_range(grid_jitter)),
                       grid_y0 + (slot / GRID_COLS) * grid_step + int'($urandom_range(grid_jitter)));
    endfunction

    // Triangle of one grid cell, vertex order rotated and at random reversed; half of them forced onto the rim cells.
    function automatic mbef_in_t grid_tri(input int slot);
        int r;
        int c;
        int n;
        int rot;
        int v [3];
        r = $urandom_range(GRID_COLS - 2);
        c = $urandom_range(GRID_COLS - 2);
        if ($urandom_range(1))
        begin
            if ($urandom_range(1))
                c = $urandom_range(1) ? 0 : GRID_COLS - 2;
            else
                r = $urandom_range(1) ? 0 : GRID_COLS - 2;
        end
        n    = r * GRID_COLS + c;
        v[0] = n;
        v[1] = $urandom_range(1) ? n + 1 : n + GRID_COLS + 1;
        v[2] = (v[1] == n + 1) ? n + GRID_COLS + 1 : n + GRID_COLS;
        rot  = $urandom_range(2);
        if ($urandom_range(1))
            return tri_of(slot, v[rot], v[(rot + 1) % 3], v[(rot + 2) % 3]);
        return tri_of(slot, v[rot], v[(rot + 2) % 3], v[(rot + 1) % 3]);
    endfunction

    function automatic int pick_count();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 1;
            2:       return 64;
            3:       return 127;
            4:       return $urandom_range(65, 126);
            default: return $urandom_range(2, 63);
        endcase
    endfunction

    // start stays high across back-to-back transfers; it is only dropped for a gap
    task automatic send_item(input mbef_in_t it);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        item  <= it;
        do @(posedge clk); while (busy);
        boundary_sb.note_item(it);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (boundary_sb.expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        boundary_sb.store_register(idx, val);
    endtask

    task automatic configure(input logic [TOL_W-1:0] tol, input int nodes, input int elems);
        set_register(CFG_TOLERANCE, CFG_DATA_W'(tol));
        set_register(CFG_NODES, CFG_DATA_W'(nodes));
        set_register(CFG_ELEMENTS, CFG_DATA_W'(elems));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        mbef_in_t         it;
        int               items_sent;
        int               burst;
        int               roll;
        int               slot;
        logic [TOL_W-1:0] tol;

        boundary_sb = new();
        items_sent  = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no nodes in use after reset: both query kinds come back empty
        send_item(make_item(KIND_Q_NODE));
        send_item(make_item(KIND_Q_EDGE));

        // square at the coordinate extremes, a center node and a node past the count
        send_item(node_at(0, COORD_MIN, COORD_MIN));
        send_item(node_at(1, COORD_MAX, COORD_MIN));
        send_item(node_at(2, COORD_MAX, COORD_MAX));
        send_item(node_at(3, COORD_MIN, COORD_MAX));
        send_item(node_at(4, 0, 0));
        send_item(node_at(63, 32'sh1234_5678, COORD_MAX - 10));
        send_item(tri_of(0, 0, 1, 2));
        send_item(tri_of(1, 0, 2, 3));
        send_item(tri_of(2, 63, 2, 4));
        send_item(tri_of(63, 63, 4, 0));

        drain_results();
        configure(TOL_RESET, 4, 3);
        for (int s = 0; s < 4; s++)
        begin
            it      = make_item(KIND_Q_NODE);
            it.side = 2'(s);
            send_item(it);
            it.kind = KIND_Q_EDGE;
            send_item(it);
        end

        // zero tolerance matches nothing, even the extreme itself
        drain_results();
        configure('0, 4, 3);
        send_item(make_item(KIND_Q_NODE));
        send_item(make_item(KIND_Q_EDGE));

        drain_results();
        configure('1, 4, 3);
        it      = make_item(KIND_Q_EDGE);
        it.side = SIDE_BOTTOM;
        send_item(it);

        // load a full 8x8 grid: all nodes first, then every triangle slot
        grid_x0     = $signed($urandom) >>> 4;
        grid_y0     = $signed($urandom) >>> 4;
        grid_step   = $urandom_range(1) ? 65536 : $urandom_range(1000, 200000);
        grid_jitter = 40;
        for (int i = 0; i < MAX_NODES + MAX_TRIANGLES; i++)
        begin
            idle_pct = (i >= 40 && i < 100) ? 0 : 29;
            if ($urandom_range(99) < 15)
            begin
                send_item(make_item($urandom_range(1) ? KIND_Q_NODE : KIND_Q_EDGE));
                items_sent++;
            end
            send_item(i < MAX_NODES ? grid_node(i) : grid_tri(i - MAX_NODES));
            items_sent++;
        end
        idle_pct = 29;

        while (items_sent < RANDOM_ITEMS)
        begin
            drain_results();
            case ($urandom_range(5))
                0:       tol = '0;
                1:       tol = TOL_RESET;
                2:       tol = '1;
                3:       tol = TOL_W'($urandom_range(200));
                4:       tol = TOL_W'($urandom_range(5000));
                default: tol = TOL_W'($urandom);
            endcase
            case ($urandom_range(2))
                0:       grid_jitter = 0;
                1:       grid_jitter = 40;
                default: grid_jitter = 300;
            endcase
            configure(tol, pick_count(), pick_count());
            burst = $urandom_range(4, 12);
            for (int i = 0; i < burst && items_sent < RANDOM_ITEMS; i++)
            begin
                roll = $urandom_range(99);
                if (roll < 50)
                    send_item(make_item($urandom_range(1) ? KIND_Q_NODE : KIND_Q_EDGE));
                else if (roll < 78)
                begin
                    // moving a node back onto the grid heals an earlier stray write
                    slot       = (stray_slot >= 0) ? stray_slot : $urandom_range(63);
                    stray_slot = -1;
                    send_item(grid_node(slot));
                end
                else if (roll < 82)
                begin
                    it         = make_item(KIND_WR_NODE);
                    stray_slot = it.slot;
                    send_item(it);
                end
                else if (roll < 95)
                    send_item(grid_tri($urandom_range(63)));
                else
                    send_item(make_item(KIND_WR_TRI));
                items_sent++;
            end
        end

        drain_results();
        repeat (4 * SETTLE_CYCLES) @(posedge clk);
        if (!boundary_sb.failed && boundary_sb.expected_hits.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
